### design/bli_pkg.sv
`default_nettype none
package bli_pkg;

  localparam int unsigned TableDepth = 64;
  localparam int unsigned IdxW = $clog2(TableDepth);
  localparam int unsigned CntW = $clog2(TableDepth + 1);
  localparam int unsigned EntryW = 64;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_QUERY  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_ORDER = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] point_time;
    logic [31:0] point_distance;
    logic [31:0] query_time;
  } in_item_t;

  typedef struct packed {
    logic [31:0] distance;
    logic [1:0]  status;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ORD_RD,
    S_ORD_CHK,
    S_SRCH_RD,
    S_SRCH_CHK,
    S_SEG_RD0,
    S_SEG_RD1,
    S_SEG_LD,
    S_MUL,
    S_DIV,
    S_FIN,
    S_OUT
  } state_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
    logic        rem_nz;
  } div_rsp_t;

endpackage
`default_nettype wire

### design/bli_ram.sv
`default_nettype none
module bli_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### design/bli_div.sv
`default_nettype none
module bli_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bli_pkg::div_req_t req,
  output bli_pkg::div_rsp_t      rsp
);
  import bli_pkg::*;

  logic [63:0] quo_r, quo_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] den_r;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] trial;
  logic [32:0] shifted;

  always_comb begin
    shifted  = {rem_r[31:0], quo_r[63]};
    trial    = shifted - {1'b0, den_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      cnt_nxt  = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_nxt = trial;
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (req.start) begin
      den_r <= req.divisor;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;
  assign rsp.rem_nz   = (rem_r != '0);

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("divider done without run");
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r != 7'd0) else $error("divider count ran out while busy");

endmodule
`default_nettype wire

### design/breakpoint_linear_interpolator_top.sv
`default_nettype none
// A clear, an unused mode, an append to a full table or a query into an empty table goes straight to
// the result. An append reads the last entry for the order check (not into an empty table) before it
// writes; a query runs a binary search of k steps, at most 7 for 64 entries, then loads the table end
// it lands on or multiplies and runs the 64-bit division to interpolate. One item is in work at a time.
// The result register lets the next input transfer in the same cycle that a result appears.
// Synchronous active-low reset empties the table and sets end_time to all ones.
module breakpoint_linear_interpolator_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire bli_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output bli_pkg::out_item_t      out_data,
  input  wire logic               cfg_we,
  input  wire logic [31:0]        cfg_wdata
);
  import bli_pkg::*;

  state_t          state_r, state_nxt;
  in_item_t        item_r;
  logic [31:0]     end_time_r;
  logic [CntW-1:0] count_r, count_nxt;
  logic [CntW-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [CntW-1:0] mid;
  logic [31:0]     t_r, t_nxt;
  logic [31:0]     ti_r, ti_nxt, di_r, di_nxt, tf_r, tf_nxt, df_r, df_nxt;
  logic [63:0]     prod_r, prod_nxt;
  logic            fall_r, fall_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_r, out_nxt;
  out_item_t       res_r, res_nxt;
  logic            we;
  logic [IdxW-1:0] waddr, raddr;
  logic [EntryW-1:0] wdata, rdata;
  div_req_t        dreq;
  div_rsp_t        drsp;
  logic [31:0]     mag, num, qv;

  bli_ram #(.Width(EntryW), .Depth(TableDepth)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  bli_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign mid = lo_r + ((hi_r - lo_r) >> 1);
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    t_nxt         = t_r;
    ti_nxt        = ti_r;
    di_nxt        = di_r;
    tf_nxt        = tf_r;
    df_nxt        = df_r;
    prod_nxt      = prod_r;
    fall_nxt      = fall_r;
    out_nxt       = out_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    we            = 1'b0;
    waddr         = count_r[IdxW-1:0];
    wdata         = {item_r.point_time, item_r.point_distance};
    raddr         = mid[IdxW-1:0];
    dreq.start    = 1'b0;
    dreq.dividend = prod_r;
    dreq.divisor  = tf_r - ti_r;
    mag           = fall_r ? (di_r - df_r) : (df_r - di_r);
    num           = t_r - ti_r;
    qv            = drsp.quotient[31:0];
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_nxt = '0;
          unique case (mode_t'(in_data.mode))
            MODE_CLEAR: begin
              count_nxt = '0;
              state_nxt = S_OUT;
            end
            MODE_APPEND: begin
              if (count_r >= CntW'(TableDepth)) begin
                res_nxt.status = ST_FULL;
                state_nxt = S_OUT;
              end else if (count_r == '0) begin
                state_nxt = S_ORD_CHK;
              end else begin
                state_nxt = S_ORD_RD;
              end
            end
            MODE_QUERY: begin
              if (count_r == '0) begin
                res_nxt.status = ST_EMPTY;
                state_nxt = S_OUT;
              end else begin
                t_nxt = (in_data.query_time > end_time_r) ? end_time_r
                                                          : in_data.query_time;
                lo_nxt = '0;
                hi_nxt = count_r;
                state_nxt = S_SRCH_RD;
              end
            end
            default: state_nxt = S_OUT;
          endcase
        end
      end
      S_ORD_RD: begin
        raddr = count_nxt[IdxW-1:0] - IdxW'(1);
        state_nxt = S_ORD_CHK;
      end
      S_ORD_CHK: begin
        if (count_r != '0 && item_r.point_time <= rdata[63:32]) begin
          res_nxt.status = ST_ORDER;
        end else begin
          we = 1'b1;
          count_nxt = count_r + CntW'(1);
        end
        state_nxt = S_OUT;
      end
      S_SRCH_RD: begin
        if (lo_r < hi_r) begin
          state_nxt = S_SRCH_CHK;
        end else if (lo_r == count_r) begin
          raddr = lo_r[IdxW-1:0] - IdxW'(1);
          state_nxt = S_SEG_LD;
          fall_nxt = 1'b1;
        end else if (lo_r == '0) begin
          raddr = '0;
          state_nxt = S_SEG_LD;
          fall_nxt = 1'b1;
        end else begin
          raddr = lo_r[IdxW-1:0];
          state_nxt = S_SEG_RD0;
          fall_nxt = 1'b0;
        end
      end
      S_SRCH_CHK: begin
        if (rdata[63:32] < t_r) begin
          lo_nxt = mid + CntW'(1);
        end else begin
          hi_nxt = mid;
        end
        state_nxt = S_SRCH_RD;
      end
      S_SEG_RD0: begin
        tf_nxt = rdata[63:32];
        df_nxt = rdata[31:0];
        raddr = lo_r[IdxW-1:0] - IdxW'(1);
        state_nxt = S_SEG_RD1;
      end
      S_SEG_RD1: begin
        ti_nxt = rdata[63:32];
        di_nxt = rdata[31:0];
        fall_nxt = (df_r < rdata[31:0]);
        state_nxt = S_MUL;
      end
      S_SEG_LD: begin
        res_nxt.distance = rdata[31:0];
        state_nxt = S_OUT;
      end
      S_MUL: begin
        prod_nxt = {32'd0, mag} * {32'd0, num};
        state_nxt = S_DIV;
        dreq.start = 1'b0;
      end
      S_DIV: begin
        dreq.start = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (drsp.done) begin
          if (fall_r) begin
            res_nxt.distance = di_r - qv - {31'd0, drsp.rem_nz};
          end else begin
            res_nxt.distance = di_r + qv;
          end
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_nxt = res_r;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      end_time_r  <= '1;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        end_time_r <= cfg_wdata;
      end
    end
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    t_r    <= t_nxt;
    ti_r   <= ti_nxt;
    di_r   <= di_nxt;
    tf_r   <= tf_nxt;
    df_r   <= df_nxt;
    prod_r <= prod_nxt;
    fall_r <= fall_nxt;
    out_r  <= out_nxt;
    res_r  <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(TableDepth)) else $error("entry count beyond table depth");
  a_search_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRCH_CHK) |-> (lo_r < hi_r && hi_r <= count_r))
    else $error("search window out of range");
  a_write_in_append: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (state_r == S_ORD_CHK && item_r.mode == MODE_APPEND))
    else $error("table write outside append");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r) && count_r != '0) |-> count_r == $past(count_r) + CntW'(1))
    else $error("entry count jumped");

endmodule
`default_nettype wire
